// File: hdl/tspt_pkg.sv
// package for the tire sensor packet tracker
// constants, types and state codes shared by every module but tspt_ram
`timescale 1ns / 1ps
package tspt_pkg;
    localparam int TABLE_ENTRIES = 16;
    localparam int SLOT_COUNT    = 4;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);
    localparam int SLOT_W        = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int ENTRY_W       = 1 + 32 + 8 + 24 + 15 + 32;
    localparam logic [4:0]  PACKET_BYTES = 5'd9;
    localparam logic [31:0] WINDOW_RESET = 32'd7200000;
    localparam logic [2:0]  REG_SEL0 = 3'd0;
    localparam logic [2:0]  REG_WINDOW = 3'd4;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_BAD_LEN = 2'd1,
        ST_BAD_CHK = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        MODE_MANUAL = 2'd0,
        MODE_ZERO   = 2'd1,
        MODE_ONE    = 2'd2
    } mode_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_WRITE,
        S_BUILD,
        S_DONE
    } state_t;

    typedef struct packed {
        logic        used;
        logic [31:0] id;
        logic [7:0]  wheel;
        logic [23:0] reading;
        logic [14:0] link;
        logic [31:0] seen;
    } entry_t;
endpackage

// File: hdl/tire_sensor_packet_tracker.sv
// top level of the tire sensor packet tracker
// depends on tspt_pkg, tspt_cfg and tspt_engine
`timescale 1ns / 1ps
// A rejected packet (wrong length or bad check byte) gives its word in the
// cycle after acceptance. For a good packet, one pass over the entry memory
// finds the match, free or oldest entry, one write stores the packet, and a
// second pass rebuilds the slot suggestions; the entry memory has a single
// read port, so each pass reads the entries one by one.
// One packet is in work at a time. Reset clears a valid bit per entry, so
// the table starts empty although the memory itself is not cleared.
module tire_sensor_packet_tracker import tspt_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [4:0]  packet_length,
    input  logic [31:0] id_word,
    input  logic [7:0]  wheel_byte,
    input  logic [7:0]  flag_pressure_byte,
    input  logic [7:0]  pressure_low_byte,
    input  logic [7:0]  temperature_byte,
    input  logic [7:0]  check_byte,
    input  logic signed [7:0] signal_strength,
    input  logic [6:0]  link_quality,
    input  logic [31:0] now_ms,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  status,
    output logic [3:0]  entry_index,
    output logic [11:0] pressure_kpa,
    output logic signed [7:0] temperature_c,
    output logic [3:0]  sensor_flags,
    output logic [3:0]  publish_mask,
    output logic [1:0]  mapping_mode,
    output logic        suggestions_changed,
    output logic [31:0] suggest_slot0,
    output logic [31:0] suggest_slot1,
    output logic [31:0] suggest_slot2,
    output logic [31:0] suggest_slot3
);
    logic [31:0] sel_id [4];
    logic [31:0] window;
    logic [7:0]  temp_u;
    logic [7:0]  rssi_u;

    assign pready = 1'b1;
    assign rssi_u = signal_strength;
    assign temperature_c = temp_u;

    tspt_cfg u_cfg (
        .clk(clk), .rst_n(rst_n), .psel(psel), .penable(penable),
        .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
        .sel_id(sel_id), .window(window)
    );

    tspt_engine u_engine (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .packet_length(packet_length), .id_word(id_word), .wheel_byte(wheel_byte),
        .flag_pressure_byte(flag_pressure_byte),
        .pressure_low_byte(pressure_low_byte),
        .temperature_byte(temperature_byte), .check_byte(check_byte),
        .signal_strength(rssi_u), .link_quality(link_quality),
        .sel_id(sel_id), .window(window), .out_valid(out_valid),
        .out_stall(out_stall), .status(status), .entry_index(entry_index),
        .pressure_kpa(pressure_kpa), .temperature_c(temp_u),
        .sensor_flags(sensor_flags), .publish_mask(publish_mask),
        .mapping_mode(mapping_mode), .suggestions_changed(suggestions_changed),
        .suggest_slot0(suggest_slot0), .suggest_slot1(suggest_slot1),
        .suggest_slot2(suggest_slot2), .suggest_slot3(suggest_slot3),
        .now_ms(now_ms)
    );
endmodule

// File: hdl/tspt_ram.sv
// generic single-port write, single read port ram with registered read
// no dependencies
`timescale 1ns / 1ps
module tspt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// File: hdl/tspt_cfg.sv
// apb register file: slot selections and visibility window
// depends on tspt_pkg
`timescale 1ns / 1ps
module tspt_cfg import tspt_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic [31:0] sel_id [4],
    output logic [31:0] window
);
    logic [31:0] sel_reg [4];
    logic [31:0] window_reg;
    logic [2:0]  ridx;

    assign ridx = paddr[4:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 4; i++) sel_reg[i] <= '0;
            window_reg <= WINDOW_RESET;
        end
        else if (psel && penable && pwrite)
        begin
            if (ridx < REG_WINDOW) sel_reg[ridx[1:0]] <= pwdata;
            else if (ridx == REG_WINDOW) window_reg <= pwdata;
        end
    end

    always_comb
    begin
        if (ridx < REG_WINDOW) prdata = sel_reg[ridx[1:0]];
        else if (ridx == REG_WINDOW) prdata = window_reg;
        else prdata = '0;
    end

    assign sel_id = sel_reg;
    assign window = window_reg;
endmodule

// File: hdl/tspt_engine.sv
// packet check, table upsert and suggestion rebuild over the entry memory
// depends on tspt_pkg and tspt_ram
`timescale 1ns / 1ps
module tspt_engine import tspt_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [4:0]  packet_length,
    input  logic [31:0] id_word,
    input  logic [7:0]  wheel_byte,
    input  logic [7:0]  flag_pressure_byte,
    input  logic [7:0]  pressure_low_byte,
    input  logic [7:0]  temperature_byte,
    input  logic [7:0]  check_byte,
    input  logic [7:0]  signal_strength,
    input  logic [6:0]  link_quality,
    input  logic [31:0] sel_id [4],
    input  logic [31:0] window,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  status,
    output logic [3:0]  entry_index,
    output logic [11:0] pressure_kpa,
    output logic [7:0]  temperature_c,
    output logic [3:0]  sensor_flags,
    output logic [3:0]  publish_mask,
    output logic [1:0]  mapping_mode,
    output logic        suggestions_changed,
    output logic [31:0] suggest_slot0,
    output logic [31:0] suggest_slot1,
    output logic [31:0] suggest_slot2,
    output logic [31:0] suggest_slot3,
    input  logic [31:0] now_ms
);
    state_t state_reg, state_next;
    logic [IDX_W:0]   cnt_reg, cnt_next;
    logic             rd_ok_reg, rd_ok_next;
    logic [IDX_W-1:0] raddr;
    entry_t           rdata, wdata;
    logic             we;
    logic [IDX_W-1:0] waddr;
    logic [TABLE_ENTRIES-1:0] vld_reg;

    logic [31:0] id_reg, now_reg;
    logic [7:0]  wheel_reg;
    logic [7:0]  fp_reg, plo_reg, temp_reg;
    logic [7:0]  rssi_reg;
    logic [6:0]  lqi_reg;
    logic        match_reg, free_reg;
    logic [IDX_W-1:0] hit_reg, free_idx_reg, old_idx_reg;
    logic [31:0] old_age_reg;
    logic        zero_seen_reg, top_seen_reg;
    logic [31:0] sugg_reg [SLOT_COUNT];
    logic [31:0] fresh_reg [SLOT_COUNT];
    logic [31:0] best_reg [SLOT_COUNT];
    logic [IDX_W-1:0] tgt_reg;

    logic        ov_reg;
    logic [1:0]  st_reg;
    logic [3:0]  idx_out_reg, mask_reg;
    logic        chg_reg;

    logic [7:0]  xsum;
    logic [31:0] age;
    logic [1:0]  mode;
    logic [IDX_W-1:0] ridx;
    logic        rd_used;
    logic        slot_ok;
    logic [SLOT_W-1:0] slot;
    logic        accept;
    logic        good;
    logic [3:0]  mask_c;
    logic        chg_c;

    tspt_ram #(.WIDTH(ENTRY_W), .DEPTH(TABLE_ENTRIES)) u_ram (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
        .raddr(raddr), .rdata(rdata)
    );

    assign accept   = in_valid && !in_stall;
    assign in_stall = (state_reg != S_IDLE) || (ov_reg && out_stall);
    assign xsum = id_word[31:24] ^ id_word[23:16] ^ id_word[15:8] ^ id_word[7:0]
                ^ wheel_byte ^ flag_pressure_byte ^ pressure_low_byte ^ temperature_byte;
    assign good = (packet_length == PACKET_BYTES) && (xsum == check_byte);
    assign ridx = cnt_reg[IDX_W-1:0] - 1'b1;
    assign raddr = cnt_reg[IDX_W-1:0];
    assign age  = now_reg - rdata.seen;
    assign rd_used = vld_reg[ridx] && rdata.used;

    always_comb
    begin
        if (zero_seen_reg && !top_seen_reg) mode = MODE_ZERO;
        else if (top_seen_reg && !zero_seen_reg) mode = MODE_ONE;
        else mode = MODE_MANUAL;
    end

    always_comb
    begin
        slot_ok = 1'b0;
        slot    = '0;
        if (mode == MODE_ZERO && {24'd0, rdata.wheel} < SLOT_COUNT)
        begin
            slot_ok = 1'b1;
            slot    = rdata.wheel[SLOT_W-1:0];
        end
        else if (mode == MODE_ONE && rdata.wheel != 8'd0
                 && {24'd0, rdata.wheel} <= SLOT_COUNT)
        begin
            slot_ok = 1'b1;
            slot    = SLOT_W'(rdata.wheel - 8'd1);
        end
    end

    always_comb
    begin
        mask_c = '0;
        for (int s = 0; s < 4 && s < SLOT_COUNT; s++)
            mask_c[s] = (sel_id[s] != '0) && (sel_id[s] == id_reg);
        chg_c = 1'b0;
        for (int s = 0; s < SLOT_COUNT; s++)
            if (sugg_reg[s] != fresh_reg[s]) chg_c = 1'b1;
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        rd_ok_next = 1'b0;
        we    = 1'b0;
        waddr = tgt_reg;
        wdata.used    = 1'b1;
        wdata.id      = id_reg;
        wdata.wheel   = wheel_reg;
        wdata.reading = {fp_reg, plo_reg, temp_reg};
        wdata.link    = {rssi_reg, lqi_reg};
        wdata.seen    = now_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && good)
                begin
                    state_next = S_SCAN;
                    cnt_next   = '0;
                end
            end
            S_SCAN, S_BUILD:
            begin
                if (cnt_reg < (IDX_W+1)'(TABLE_ENTRIES))
                begin
                    cnt_next   = cnt_reg + 1'b1;
                    rd_ok_next = 1'b1;
                end
                else if (!rd_ok_reg)
                begin
                    state_next = (state_reg == S_SCAN) ? S_WRITE : S_DONE;
                    cnt_next   = '0;
                end
            end
            S_WRITE:
            begin
                we = 1'b1;
                state_next = S_BUILD;
                cnt_next   = '0;
            end
            S_DONE:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            rd_ok_reg     <= 1'b0;
            ov_reg        <= 1'b0;
            vld_reg       <= '0;
            zero_seen_reg <= 1'b0;
            top_seen_reg  <= 1'b0;
            for (int s = 0; s < SLOT_COUNT; s++) sugg_reg[s] <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            rd_ok_reg <= rd_ok_next;
            if (state_reg == S_DONE || (accept && !good)) ov_reg <= 1'b1;
            else if (!out_stall) ov_reg <= 1'b0;
            if (state_reg == S_WRITE)
            begin
                vld_reg[tgt_reg] <= 1'b1;
                if (wheel_reg == 8'd0) zero_seen_reg <= 1'b1;
                if ({24'd0, wheel_reg} == SLOT_COUNT) top_seen_reg <= 1'b1;
            end
            if (state_reg == S_DONE)
            begin
                for (int s = 0; s < SLOT_COUNT; s++) sugg_reg[s] <= fresh_reg[s];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            id_reg    <= id_word;
            now_reg   <= now_ms;
            wheel_reg <= wheel_byte;
            fp_reg    <= flag_pressure_byte;
            plo_reg   <= pressure_low_byte;
            temp_reg  <= temperature_byte;
            rssi_reg  <= signal_strength;
            lqi_reg   <= link_quality;
            match_reg <= 1'b0;
            free_reg  <= 1'b0;
            old_age_reg <= '0;
            old_idx_reg <= '0;
            if (packet_length != PACKET_BYTES) st_reg <= ST_BAD_LEN;
            else if (xsum != check_byte) st_reg <= ST_BAD_CHK;
            else st_reg <= ST_OK;
            idx_out_reg <= '0;
            mask_reg    <= '0;
            chg_reg     <= 1'b0;
        end
        if (state_reg == S_SCAN && rd_ok_reg)
        begin
            if (rd_used && rdata.id == id_reg && !match_reg)
            begin
                match_reg <= 1'b1;
                hit_reg   <= ridx;
            end
            if (!free_reg)
            begin
                if (!rd_used)
                begin
                    free_reg     <= 1'b1;
                    free_idx_reg <= ridx;
                end
                else if (age >= old_age_reg)
                begin
                    old_age_reg <= age;
                    old_idx_reg <= ridx;
                end
            end
        end
        if (state_reg == S_SCAN && state_next == S_WRITE)
        begin
            if (match_reg) tgt_reg <= hit_reg;
            else if (free_reg) tgt_reg <= free_idx_reg;
            else tgt_reg <= old_idx_reg;
        end
        if (state_reg == S_WRITE)
        begin
            for (int s = 0; s < SLOT_COUNT; s++)
            begin
                fresh_reg[s] <= '0;
                best_reg[s]  <= '0;
            end
        end
        if (state_reg == S_BUILD && rd_ok_reg && rd_used && age <= window && slot_ok
            && rdata.seen >= best_reg[slot])
        begin
            best_reg[slot]  <= rdata.seen;
            fresh_reg[slot] <= rdata.id;
        end
        if (state_reg == S_DONE)
        begin
            idx_out_reg <= 4'(tgt_reg);
            mask_reg    <= mask_c;
            chg_reg     <= chg_c;
        end
    end

    assign out_valid    = ov_reg;
    assign status       = st_reg;
    assign entry_index  = idx_out_reg;
    assign pressure_kpa = (st_reg == ST_OK) ? {fp_reg[3:0], plo_reg} : '0;
    assign temperature_c = (st_reg == ST_OK) ? temp_reg : '0;
    assign sensor_flags = (st_reg == ST_OK) ? fp_reg[7:4] : '0;
    assign publish_mask = mask_reg;
    assign mapping_mode = mode;
    assign suggestions_changed = chg_reg;
    assign suggest_slot0 = sugg_reg[0];
    assign suggest_slot1 = (SLOT_COUNT > 1) ? sugg_reg[1 % SLOT_COUNT] : '0;
    assign suggest_slot2 = (SLOT_COUNT > 2) ? sugg_reg[2 % SLOT_COUNT] : '0;
    assign suggest_slot3 = (SLOT_COUNT > 3) ? sugg_reg[3 % SLOT_COUNT] : '0;
endmodule

// File: hdl/tspt_checker.sv
// port-level checks for the tire sensor packet tracker, with bind
// depends on tspt_pkg
`timescale 1ns / 1ps
module tspt_checker import tspt_pkg::*; (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [1:0]  status,
    input logic [3:0]  entry_index,
    input logic [3:0]  publish_mask,
    input logic        suggestions_changed
);
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(status))
        else $error("stalled word dropped");
    a_no_take_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall || out_valid)
        else $error("accepted packet neither in work nor answered");
    a_reject_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_OK |-> entry_index == '0 && publish_mask == '0
        && !suggestions_changed)
        else $error("rejected word carries update fields");
    a_status_legal: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> status == ST_OK || status == ST_BAD_LEN || status == ST_BAD_CHK)
        else $error("bad status code");
endmodule

bind tire_sensor_packet_tracker tspt_checker u_checker (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .status(status),
    .entry_index(entry_index), .publish_mask(publish_mask),
    .suggestions_changed(suggestions_changed)
);
